// File: sv/can_io_expander_command_decoder_macros.svh
// assertion macros used by the checker file
`ifndef CAN_IO_EXPANDER_COMMAND_DECODER_MACROS_SVH
`define CAN_IO_EXPANDER_COMMAND_DECODER_MACROS_SVH

// property checked on every clock edge outside reset
`define CIOX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every clock edge, reset included
`define CIOX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/ciox_pkg.sv
// types and constants of the can io expander command decoder
package ciox_pkg;

  localparam int unsigned ANALOG_CHANNELS = 2;
  localparam int unsigned PWM_CHANNELS    = 2;

  localparam logic [11:0] BASE_ID        = 12'h200;
  localparam int unsigned ID_STRIDE_LOG2 = 5;      // stride of 0x20 between devices
  localparam logic [11:0] LAST_IN        = 12'h005;
  localparam logic [11:0] WHOAMI_OFS     = 12'h008;

  localparam logic [7:0]  FW_VERSION       = 8'd1;
  localparam logic [15:0] PWM_PERIOD_CODE  = 16'd5000;
  localparam logic [15:0] TACH_PERIOD_CODE = 16'd66;
  localparam logic [63:0] REPLY_PAYLOAD    =
    {FW_VERSION, 24'd0, PWM_PERIOD_CODE, TACH_PERIOD_CODE};

  localparam logic [7:0] INTERVAL_RESET = 8'd20;

  localparam logic [3:0] LEN_PING = 4'd0;
  localparam logic [3:0] LEN_FULL = 4'd8;
  localparam logic [3:0] LEN_LAST = 4'd5;

  // quotient bits per channel: bit 16 plus 16 fraction bits
  localparam int unsigned DIV_STEPS = 17;
  localparam logic [4:0]  LAST_STEP = 5'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    OFS_PING   = 3'd0,
    OFS_CONFIG = 3'd1,
    OFS_ANALOG = 3'd2,
    OFS_PWM    = 3'd3,
    OFS_SPARE  = 3'd4,
    OFS_LAST   = 3'd5
  } frame_ofs_e;

  typedef enum logic [1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_DEV_OFFSET  = 2'd1,
    CFG_ANALOG_MASK = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ACT_IGNORE    = 3'd0,
    ACT_IDENTIFY  = 3'd1,
    ACT_CONFIG    = 3'd2,
    ACT_ANALOG    = 3'd3,
    ACT_PWM       = 3'd4,
    ACT_NO_EFFECT = 3'd5
  } action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_e;

  typedef struct packed {
    logic [10:0] can_id;
    logic        is_extended;
    logic [3:0]  length;
    logic [63:0] payload;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [10:0] reply_id;
    logic [63:0] reply_payload;
    logic [16:0] duty_a;
    logic        write_a;
    logic [16:0] duty_b;
    logic        write_b;
    logic        is_configured;
    logic [7:0]  adc_interval_ms;
    logic [7:0]  tach_interval_ms;
    logic [7:0]  pwm_select_mask;
    logic [7:0]  tach_input_mask;
  } out_item_t;

endpackage

// File: sv/can_io_expander_command_decoder.sv
// can io expander command decoder: frame decode and serial duty divider
//
// Usage: one received CAN frame enters per item on the in channel
// (valid/ready); exactly one result item leaves on the out channel.
// Configuration registers (enable, device offset, analog mask) are written
// through the cfg channel, which is always ready; write them only while idle.
// Ping, config, ignored and no-effect frames load the output register in the
// cycle the item is accepted, so the result shows in the next cycle.
// Analog and PWM duty frames that write a channel run two restoring
// divisions of 17 steps each on a single shared subtract-compare unit, one
// quotient bit per cycle; the next item can enter in the same cycle the
// result is taken.
// One item is in work at a time. A result that the receiver stalls stays in
// the output register unchanged; the next item is taken as soon as that
// result leaves. Reset clears the output valid, the configuration registers
// and the stored masks and flag, and sets both intervals to 20 ms.
module can_io_expander_command_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ciox_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ciox_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [5:0]          cfg_data_i
);

  ciox_pkg::state_e state_q, state_d;

  // configuration registers
  logic       enable_q;
  logic [5:0] dev_off_q;
  logic [1:0] an_mask_q;

  // stored device state
  logic       cfgd_q, cfgd_d;
  logic [7:0] pwm_sel_q, pwm_sel_d;
  logic [7:0] tach_mask_q, tach_mask_d;
  logic [7:0] adc_int_q, adc_int_d;
  logic [7:0] tach_int_q, tach_int_d;

  logic       out_valid_q;
  ciox_pkg::out_item_t out_q;

  // divider datapath
  logic [17:0] rem_q, rem_next, rem_diff, rem_sel;
  logic [16:0] period_q;
  logic [16:0] quot_q, quot_next;
  logic        quot_bit;
  logic [4:0]  step_q;
  logic        ch_q;
  logic [16:0] duty0_q;
  logic [16:0] duty_fin;
  logic [31:0] pay_lo_q;
  logic        wr_a_q, wr_b_q;
  ciox_pkg::action_e act_q;

  // decode
  logic [11:0] base_id, rx_id_ext, ofs_full;
  logic        in_window;
  ciox_pkg::frame_ofs_e ofs;
  ciox_pkg::action_e    act;
  logic        wr_a, wr_b, need_div;

  // sequencer strobes
  logic in_accept, out_take, load_ch1, div_done;

  assign in_accept = in_valid_i && in_ready_o;
  assign out_take  = out_valid_q && out_ready_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    base_id      = ciox_pkg::BASE_ID + (12'(dev_off_q) << ciox_pkg::ID_STRIDE_LOG2);
    rx_id_ext    = {1'b0, in_data_i.can_id};
    in_window    = enable_q && !in_data_i.is_extended && (rx_id_ext >= base_id) &&
                   (rx_id_ext <= base_id + ciox_pkg::LAST_IN);
    ofs_full     = rx_id_ext - base_id;
    ofs          = ciox_pkg::frame_ofs_e'(ofs_full[2:0]);
    act  = ciox_pkg::ACT_IGNORE;
    wr_a = 1'b0;
    wr_b = 1'b0;
    if (in_window) begin
      case (ofs)
        ciox_pkg::OFS_PING: begin
          if (in_data_i.length == ciox_pkg::LEN_PING) act = ciox_pkg::ACT_IDENTIFY;
        end
        ciox_pkg::OFS_CONFIG: begin
          if (in_data_i.length == ciox_pkg::LEN_FULL) act = ciox_pkg::ACT_CONFIG;
        end
        ciox_pkg::OFS_ANALOG: begin
          if (in_data_i.length == ciox_pkg::LEN_FULL) begin
            act  = ciox_pkg::ACT_ANALOG;
            wr_a = an_mask_q[0] && (ciox_pkg::ANALOG_CHANNELS > 0);
            wr_b = an_mask_q[1] && (ciox_pkg::ANALOG_CHANNELS > 1);
          end
        end
        ciox_pkg::OFS_PWM: begin
          if (in_data_i.length == ciox_pkg::LEN_FULL) begin
            act  = (ciox_pkg::PWM_CHANNELS > 0) ? ciox_pkg::ACT_PWM
                                                 : ciox_pkg::ACT_NO_EFFECT;
            wr_a = (ciox_pkg::PWM_CHANNELS > 0);
            wr_b = (ciox_pkg::PWM_CHANNELS > 1);
          end
        end
        ciox_pkg::OFS_SPARE: begin
          if (in_data_i.length == ciox_pkg::LEN_FULL) act = ciox_pkg::ACT_NO_EFFECT;
        end
        ciox_pkg::OFS_LAST: begin
          if (in_data_i.length == ciox_pkg::LEN_LAST) act = ciox_pkg::ACT_NO_EFFECT;
        end
        default: act = ciox_pkg::ACT_IGNORE;
      endcase
    end
    need_div = wr_a || wr_b;
  end

  // stored state after this item
  always_comb begin
    cfgd_d      = cfgd_q;
    pwm_sel_d   = pwm_sel_q;
    tach_mask_d = tach_mask_q;
    adc_int_d   = adc_int_q;
    tach_int_d  = tach_int_q;
    if (in_accept && act == ciox_pkg::ACT_CONFIG) begin
      cfgd_d      = 1'b1;
      pwm_sel_d   = in_data_i.payload[63:56];
      tach_mask_d = in_data_i.payload[47:40];
      adc_int_d   = in_data_i.payload[31:24];
      tach_int_d  = in_data_i.payload[23:16];
    end
  end

  // shared subtract-compare unit, one quotient bit per cycle
  always_comb begin
    rem_diff  = rem_q - {1'b0, period_q};
    quot_bit  = (rem_q >= {1'b0, period_q});
    rem_sel   = quot_bit ? rem_diff : rem_q;
    rem_next  = {rem_sel[16:0], 1'b0};
    quot_next = {quot_q[15:0], quot_bit};
    duty_fin  = (period_q == 17'd0) ? 17'd0 : quot_next;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    load_ch1   = 1'b0;
    div_done   = 1'b0;
    case (state_q)
      ciox_pkg::ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_accept && need_div) state_d = ciox_pkg::ST_DIV;
      end
      ciox_pkg::ST_DIV: begin
        if (step_q == ciox_pkg::LAST_STEP) begin
          if (!ch_q) begin
            load_ch1 = 1'b1;
          end else begin
            div_done = 1'b1;
            state_d  = ciox_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = ciox_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ciox_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      enable_q    <= 1'b0;
      dev_off_q   <= '0;
      an_mask_q   <= '0;
      cfgd_q      <= 1'b0;
      pwm_sel_q   <= '0;
      tach_mask_q <= '0;
      adc_int_q   <= ciox_pkg::INTERVAL_RESET;
      tach_int_q  <= ciox_pkg::INTERVAL_RESET;
    end else begin
      state_q     <= state_d;
      cfgd_q      <= cfgd_d;
      pwm_sel_q   <= pwm_sel_d;
      tach_mask_q <= tach_mask_d;
      adc_int_q   <= adc_int_d;
      tach_int_q  <= tach_int_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ciox_pkg::CFG_ENABLE:      enable_q  <= cfg_data_i[0];
          ciox_pkg::CFG_DEV_OFFSET:  dev_off_q <= cfg_data_i;
          ciox_pkg::CFG_ANALOG_MASK: an_mask_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if ((in_accept && !need_div) || div_done) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q    <= act;
      wr_a_q   <= wr_a;
      wr_b_q   <= wr_b;
      pay_lo_q <= in_data_i.payload[31:0];
      rem_q    <= {2'b00, in_data_i.payload[63:48]};
      period_q <= {1'b0, in_data_i.payload[63:48]} + {1'b0, in_data_i.payload[47:32]};
      step_q   <= '0;
      ch_q     <= 1'b0;
      if (!need_div) begin
        out_q.action        <= act;
        out_q.reply_id      <= (act == ciox_pkg::ACT_IDENTIFY) ?
                               11'(base_id + ciox_pkg::WHOAMI_OFS) : 11'd0;
        out_q.reply_payload <= (act == ciox_pkg::ACT_IDENTIFY) ?
                               ciox_pkg::REPLY_PAYLOAD : 64'd0;
        out_q.duty_a        <= '0;
        out_q.write_a       <= 1'b0;
        out_q.duty_b        <= '0;
        out_q.write_b       <= 1'b0;
      end
    end else if (state_q == ciox_pkg::ST_DIV) begin
      quot_q <= quot_next;
      if (load_ch1) begin
        duty0_q  <= duty_fin;
        rem_q    <= {2'b00, pay_lo_q[31:16]};
        period_q <= {1'b0, pay_lo_q[31:16]} + {1'b0, pay_lo_q[15:0]};
        step_q   <= '0;
        ch_q     <= 1'b1;
      end else begin
        rem_q  <= rem_next;
        step_q <= step_q + 5'd1;
      end
      if (div_done) begin
        out_q.action        <= act_q;
        out_q.reply_id      <= '0;
        out_q.reply_payload <= '0;
        out_q.duty_a        <= wr_a_q ? duty0_q : 17'd0;
        out_q.write_a       <= wr_a_q;
        out_q.duty_b        <= wr_b_q ? duty_fin : 17'd0;
        out_q.write_b       <= wr_b_q;
      end
    end
    // status fields always show the stored state after the item
    if ((in_accept && !need_div) || div_done) begin
      out_q.is_configured    <= cfgd_d;
      out_q.adc_interval_ms  <= adc_int_d;
      out_q.tach_interval_ms <= tach_int_d;
      out_q.pwm_select_mask  <= pwm_sel_d;
      out_q.tach_input_mask  <= tach_mask_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/ciox_checker.sv
// port-level checker for the can io expander command decoder, with its bind
`include "can_io_expander_command_decoder_macros.svh"

module ciox_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ciox_pkg::out_item_t out_data_o
);

  // a stalled result item keeps its slot and contents
  `CIOX_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result item dropped or changed while stalled")

  `CIOX_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid during reset")

  // reply fields are only filled for an identify reply
  `CIOX_ASSERT(a_reply_only_identify, out_valid_o && out_data_o.action != ciox_pkg::ACT_IDENTIFY |-> out_data_o.reply_id == 11'd0 && out_data_o.reply_payload == 64'd0, "reply fields set outside identify")

  // duties stay in range and read zero on channels not written
  `CIOX_ASSERT(a_duty_gated, out_valid_o |-> (out_data_o.write_a || out_data_o.duty_a == 17'd0) && (out_data_o.write_b || out_data_o.duty_b == 17'd0) && out_data_o.duty_a <= 17'h10000 && out_data_o.duty_b <= 17'h10000, "duty out of range or set on an unwritten channel")

  // only duty frames update channels
  `CIOX_ASSERT(a_write_only_duty, out_valid_o && (out_data_o.write_a || out_data_o.write_b) |-> out_data_o.action == ciox_pkg::ACT_ANALOG || out_data_o.action == ciox_pkg::ACT_PWM, "channel write on a non-duty item")

endmodule

bind can_io_expander_command_decoder ciox_checker u_ciox_checker (.*);
